// ----- sv/wp16m_pkg.sv -----
`timescale 1ns / 1ps

package wp16m_pkg;

    localparam logic [2:0] ST_SAMPLE      = 3'd0;
    localparam logic [2:0] ST_BAD_TAG     = 3'd1;
    localparam logic [2:0] ST_SHORT_FMT   = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_EMPTY       = 3'd4;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    typedef struct packed {
        logic               valid;
        logic [2:0]         status;
        logic signed [16:0] mono_sample;
        logic [31:0]        sample_rate;
        logic [15:0]        channel_count;
        logic               last_sample;
    } t_result;

endpackage

// ----- sv/wp16m_parser.sv -----
`timescale 1ns / 1ps

module wp16m_parser
    import wp16m_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_first_byte,
    output t_result       o_result
);

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_CHUNK_HDR = 3'd1;
    localparam logic [2:0] PH_FMT       = 3'd2;
    localparam logic [2:0] PH_SKIP      = 3'd3;
    localparam logic [2:0] PH_DATA      = 3'd4;
    localparam logic [2:0] PH_IDLE      = 3'd5;

    logic [2:0]  r_phase, n_phase, b_phase;
    logic [31:0] r_pos, n_pos, b_pos;
    logic [31:0] r_tag, n_tag, b_tag;
    logic [31:0] r_len, n_len, b_len;
    logic [15:0] r_fmt, n_fmt, b_fmt;
    logic [15:0] r_chan, n_chan, b_chan;
    logic [31:0] r_rate, n_rate, b_rate;
    logic [15:0] r_bits, n_bits, b_bits;
    logic [7:0]  r_low, n_low, b_low;
    logic [15:0] r_left, n_left, b_left;

    logic [31:0] len_m1;
    logic [31:0] remaining;
    logic        body_end;
    logic        frame4;
    logic [1:0]  k;
    logic [15:0] word;
    t_result     res;

    always_comb begin
        if (i_first_byte) begin
            b_phase = PH_HEADER;
            b_pos   = '0;
            b_tag   = '0;
            b_len   = '0;
            b_fmt   = '0;
            b_chan  = '0;
            b_rate  = '0;
            b_bits  = '0;
            b_low   = '0;
            b_left  = '0;
        end else begin
            b_phase = r_phase;
            b_pos   = r_pos;
            b_tag   = r_tag;
            b_len   = r_len;
            b_fmt   = r_fmt;
            b_chan  = r_chan;
            b_rate  = r_rate;
            b_bits  = r_bits;
            b_low   = r_low;
            b_left  = r_left;
        end
    end

    assign len_m1    = b_len - 32'd1;
    assign remaining = len_m1 - b_pos;
    assign body_end  = (b_pos >= len_m1);
    assign frame4    = (b_chan == 16'd2);
    assign k         = frame4 ? b_pos[1:0] : {1'b0, b_pos[0]};
    assign word      = {i_data_byte, b_low};

    always_comb begin
        n_phase = b_phase;
        n_pos   = b_pos;
        n_tag   = b_tag;
        n_len   = b_len;
        n_fmt   = b_fmt;
        n_chan  = b_chan;
        n_rate  = b_rate;
        n_bits  = b_bits;
        n_low   = b_low;
        n_left  = b_left;
        res               = '0;
        res.sample_rate   = b_rate;
        res.channel_count = b_chan;

        case (b_phase)
            PH_HEADER: begin
                n_tag = {b_tag[23:0], i_data_byte};
                if (b_pos == 32'd3 && n_tag != TAG_RIFF) begin
                    n_phase    = PH_IDLE;
                    res.valid  = 1'b1;
                    res.status = ST_BAD_TAG;
                end else if (b_pos == 32'd11) begin
                    if (n_tag != TAG_WAVE) begin
                        n_phase    = PH_IDLE;
                        res.valid  = 1'b1;
                        res.status = ST_BAD_TAG;
                    end else begin
                        n_phase = PH_CHUNK_HDR;
                        n_pos   = '0;
                    end
                end else begin
                    n_pos = b_pos + 32'd1;
                end
            end

            PH_CHUNK_HDR: begin
                if (b_pos < 32'd4) begin
                    n_tag = {b_tag[23:0], i_data_byte};
                    if (b_pos == 32'd0) begin
                        n_len = '0;
                    end
                    n_pos = b_pos + 32'd1;
                end else begin
                    case (b_pos[1:0])
                        2'd0:    n_len[7:0]   = b_len[7:0]   | i_data_byte;
                        2'd1:    n_len[15:8]  = b_len[15:8]  | i_data_byte;
                        2'd2:    n_len[23:16] = b_len[23:16] | i_data_byte;
                        default: n_len[31:24] = b_len[31:24] | i_data_byte;
                    endcase
                    if (b_pos < 32'd7) begin
                        n_pos = b_pos + 32'd1;
                    end else begin
                        n_pos = '0;
                        if (b_tag == TAG_FMT) begin
                            if (n_len < 32'd16) begin
                                n_phase    = PH_IDLE;
                                res.valid  = 1'b1;
                                res.status = ST_SHORT_FMT;
                            end else begin
                                n_phase = PH_FMT;
                            end
                        end else if (b_tag == TAG_DATA) begin
                            if (b_fmt != 16'd1 || b_bits != 16'd16 ||
                                b_chan < 16'd1 || b_chan > 16'd2) begin
                                n_phase    = PH_IDLE;
                                res.valid  = 1'b1;
                                res.status = ST_UNSUPPORTED;
                            end else if (n_len == 32'd0) begin
                                n_phase    = PH_IDLE;
                                res.valid  = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end else if (n_len != 32'd0) begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
            end

            PH_FMT: begin
                if (b_pos == 32'd0) begin
                    n_fmt = {8'd0, i_data_byte};
                end else if (b_pos == 32'd1) begin
                    n_fmt[15:8] = i_data_byte;
                end else if (b_pos == 32'd2) begin
                    n_chan = {8'd0, i_data_byte};
                end else if (b_pos == 32'd3) begin
                    n_chan[15:8] = i_data_byte;
                end else if (b_pos == 32'd4) begin
                    n_rate = {24'd0, i_data_byte};
                end else if (b_pos == 32'd5) begin
                    n_rate[15:8] = i_data_byte;
                end else if (b_pos == 32'd6) begin
                    n_rate[23:16] = i_data_byte;
                end else if (b_pos == 32'd7) begin
                    n_rate[31:24] = i_data_byte;
                end else if (b_pos == 32'd14) begin
                    n_bits = {8'd0, i_data_byte};
                end else if (b_pos == 32'd15) begin
                    n_bits[15:8] = i_data_byte;
                end
                if (body_end) begin
                    n_phase = PH_CHUNK_HDR;
                    n_pos   = '0;
                end else begin
                    n_pos = b_pos + 32'd1;
                end
            end

            PH_SKIP: begin
                if (body_end) begin
                    n_phase = PH_CHUNK_HDR;
                    n_pos   = '0;
                end else begin
                    n_pos = b_pos + 32'd1;
                end
            end

            PH_DATA: begin
                if (!k[0]) begin
                    n_low = i_data_byte;
                end else if (k == 2'd1 && frame4) begin
                    n_left = word;
                end else begin
                    res.valid  = 1'b1;
                    res.status = ST_SAMPLE;
                    if (frame4) begin
                        res.mono_sample = $signed({b_left[15], b_left})
                                        + $signed({word[15], word});
                        res.last_sample = (remaining < 32'd4);
                    end else begin
                        res.mono_sample = $signed({word, 1'b0});
                        res.last_sample = (remaining < 32'd2);
                    end
                end
                if (remaining == 32'd0) begin
                    n_phase = PH_IDLE;
                    n_pos   = '0;
                end else begin
                    n_pos = b_pos + 32'd1;
                end
            end

            default: begin
                n_phase = b_phase;
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_tag   <= '0;
            r_len   <= '0;
            r_fmt   <= '0;
            r_chan  <= '0;
            r_rate  <= '0;
            r_bits  <= '0;
            r_low   <= '0;
            r_left  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_fmt   <= n_fmt;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
            r_low   <= n_low;
            r_left  <= n_left;
        end
    end

endmodule

// ----- sv/wp16m_out_stage.sv -----
`timescale 1ns / 1ps

module wp16m_out_stage
    import wp16m_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_accept,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_accept = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_result     = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- sv/wav_pcm16_stream_to_mono_unit.sv -----
`timescale 1ns / 1ps

// Parses a RIFF/WAVE file arriving one byte per request on the slave stream
// and gives one mono sample per complete 16-bit PCM frame on the master stream.
// The first byte of every file is flagged by the slave tuser bit, which clears
// the parser and any format fields held from an earlier file.
// Each byte passes through the combinational parser logic into a single output
// register, so a result appears on the master side in the cycle after the byte
// that causes it is accepted. One byte is taken in every cycle unless a result
// is stalled; header bytes, skipped chunks and partial frames give no result.
// The master tuser carries the status: zero for a sample, otherwise an error,
// after which bytes are dropped until the next first byte. tlast marks the
// final complete frame of the data chunk.
// When the receiver stalls, the output register holds its result and the slave
// side stays ready only if that register is being emptied in the same cycle.
// Reset clears the parser to the file header phase and empties the output
// register.
module wav_pcm16_stream_to_mono_unit
    import wp16m_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] first_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [16:0] mono_sample, [48:17] sample_rate,
                                          // [64:49] channel_count, [71:65] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast
);

    logic    accept;
    logic    can_accept;
    t_result parsed;
    t_result held;

    assign accept          = i_s_axis_tvalid && can_accept;
    assign o_s_axis_tready = can_accept;

    wp16m_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_s_axis_tdata),
        .i_first_byte (i_s_axis_tuser),
        .o_result     (parsed)
    );

    wp16m_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_result     (parsed),
        .i_ready      (i_m_axis_tready),
        .o_can_accept (can_accept),
        .o_valid      (o_m_axis_tvalid),
        .o_result     (held)
    );

    assign o_m_axis_tdata = {7'd0, held.channel_count, held.sample_rate, held.mono_sample};
    assign o_m_axis_tuser = held.status;
    assign o_m_axis_tlast = held.last_sample;

endmodule

// ----- sv/wp16m_checker.sv -----
`timescale 1ns / 1ps

module wp16m_checker
    import wp16m_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // A stalled result must hold its value until it is taken.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("master request changed while stalled");

    // An error report carries no sample and no end marker.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_SAMPLE |->
            o_m_axis_tdata[16:0] == 17'd0 && !o_m_axis_tlast)
        else $error("error report with sample data");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tuser == ST_SAMPLE || o_m_axis_tuser == ST_BAD_TAG ||
            o_m_axis_tuser == ST_SHORT_FMT || o_m_axis_tuser == ST_UNSUPPORTED ||
            o_m_axis_tuser == ST_EMPTY)
        else $error("undefined status code");

    // With the output register empty, the slave side must be ready.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("slave side blocked with nothing pending");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind wav_pcm16_stream_to_mono_unit wp16m_checker u_wp16m_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import wp16m_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_CHUNK_HDR, PH_FMT, PH_SKIP, PH_DATA, PH_IDLE
    } t_parse_phase;

    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] mono;
        logic [31:0] rate;
        logic [15:0] chans;
        logic        last;
    } t_wav_result;

    typedef struct packed {
        logic [7:0]  b;
        logic        first;
        logic        pin;
        t_wav_result res;
    } t_stim_row;

    localparam int STALL_LIMIT = 400;
    localparam int N_SHAPED    = 15;
    localparam int TOTAL_BYTES = 1200;

    localparam t_wav_result NO_RESULT = '0;
    localparam t_wav_result TAG_ERROR = {ST_BAD_TAG, 17'd0, 32'd0, 16'd0, 1'b0};

    // The first four rows arrive without a first-byte flag straight after reset.
    localparam t_stim_row DIR_ROWS [0:21] = '{
        {8'h52, 1'b0, 1'b0, NO_RESULT}, {8'h49, 1'b0, 1'b0, NO_RESULT},
        {8'h46, 1'b0, 1'b0, NO_RESULT}, {8'h58, 1'b0, 1'b1, TAG_ERROR},
        {8'hFF, 1'b0, 1'b0, NO_RESULT}, {8'h00, 1'b0, 1'b0, NO_RESULT},
        {8'h52, 1'b1, 1'b0, NO_RESULT}, {8'h49, 1'b0, 1'b0, NO_RESULT},
        {8'h46, 1'b0, 1'b0, NO_RESULT}, {8'h46, 1'b0, 1'b0, NO_RESULT},
        {8'h00, 1'b0, 1'b0, NO_RESULT}, {8'hFF, 1'b0, 1'b0, NO_RESULT},
        {8'h80, 1'b0, 1'b0, NO_RESULT}, {8'h7F, 1'b0, 1'b0, NO_RESULT},
        {8'h57, 1'b0, 1'b0, NO_RESULT}, {8'h41, 1'b0, 1'b0, NO_RESULT},
        {8'h56, 1'b0, 1'b0, NO_RESULT}, {8'h58, 1'b0, 1'b1, TAG_ERROR},
        {8'h51, 1'b1, 1'b0, NO_RESULT}, {8'h49, 1'b0, 1'b0, NO_RESULT},
        {8'h46, 1'b0, 1'b0, NO_RESULT}, {8'h46, 1'b0, 1'b1, TAG_ERROR}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic        s_first;
    logic        m_valid;
    logic        m_ready;
    logic [71:0] m_data;
    logic [2:0]  m_status;
    logic        m_last;

    logic        s_pin;
    t_wav_result s_pin_res;
    logic        gaps_on;
    int          failures;
    int          bytes_sent;
    int          quiet_cycles;
    logic [7:0]  file_q [$];
    t_wav_result expected_q [$];

    t_parse_phase w_phase;
    logic [31:0]  w_pos;
    logic [31:0]  w_tag;
    logic [31:0]  w_len;
    logic [15:0]  w_format;
    logic [15:0]  w_chans;
    logic [31:0]  w_rate;
    logic [15:0]  w_bits;
    logic [7:0]   w_low;
    logic [15:0]  w_left;

    wav_pcm16_stream_to_mono_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_first),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_status),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic clear_parser();
        w_phase  = PH_HEADER;
        w_pos    = '0;
        w_tag    = '0;
        w_len    = '0;
        w_format = '0;
        w_chans  = '0;
        w_rate   = '0;
        w_bits   = '0;
        w_low    = '0;
        w_left   = '0;
    endtask

    function automatic t_wav_result pack_result(logic [2:0] st, logic [16:0] smp, logic lst);
        t_wav_result r;
        r.status = st;
        r.mono   = smp;
        r.rate   = w_rate;
        r.chans  = w_chans;
        r.last   = lst;
        return r;
    endfunction

    task automatic raise_error(input logic [2:0] st, output logic got, output t_wav_result r);
        w_phase = PH_IDLE;
        got = 1'b1;
        r = pack_result(st, 17'd0, 1'b0);
    endtask

    task automatic advance_body();
        if (w_pos >= w_len - 32'd1) begin
            w_phase = PH_CHUNK_HDR;
            w_pos = '0;
        end else begin
            w_pos = w_pos + 32'd1;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic first,
                              output logic got, output t_wav_result r);
        logic [31:0] pos;
        logic [31:0] frame_len;
        logic [31:0] k;
        logic [31:0] remaining;
        logic [15:0] word;
        logic [16:0] sum;
        got = 1'b0;
        r = NO_RESULT;
        if (first)
            clear_parser();
        pos = w_pos;
        case (w_phase)
            PH_HEADER: begin
                w_tag = {w_tag[23:0], b};
                if ((pos == 3 && w_tag != TAG_RIFF) || (pos == 11 && w_tag != TAG_WAVE)) begin
                    raise_error(ST_BAD_TAG, got, r);
                end else if (pos == 11) begin
                    w_phase = PH_CHUNK_HDR;
                    w_pos = '0;
                end else begin
                    w_pos = pos + 32'd1;
                end
            end
            PH_CHUNK_HDR: begin
                if (pos < 4) begin
                    w_tag = {w_tag[23:0], b};
                    if (pos == 0)
                        w_len = '0;
                    w_pos = pos + 32'd1;
                end else begin
                    w_len = w_len | ({24'd0, b} << (8 * (pos - 4)));
                    if (pos < 7) begin
                        w_pos = pos + 32'd1;
                    end else begin
                        w_pos = '0;
                        if (w_tag == TAG_FMT) begin
                            if (w_len < 16)
                                raise_error(ST_SHORT_FMT, got, r);
                            else
                                w_phase = PH_FMT;
                        end else if (w_tag == TAG_DATA) begin
                            if (w_format != 16'd1 || w_bits != 16'd16 ||
                                w_chans < 16'd1 || w_chans > 16'd2)
                                raise_error(ST_UNSUPPORTED, got, r);
                            else if (w_len == 0)
                                raise_error(ST_EMPTY, got, r);
                            else
                                w_phase = PH_DATA;
                        end else if (w_len != 0) begin
                            w_phase = PH_SKIP;
                        end
                    end
                end
            end
            PH_FMT: begin
                case (pos)
                    0: w_format = {8'h00, b};
                    1: w_format[15:8] = b;
                    2: w_chans = {8'h00, b};
                    3: w_chans[15:8] = b;
                    4: w_rate = {24'h0, b};
                    5: w_rate[15:8] = b;
                    6: w_rate[23:16] = b;
                    7: w_rate[31:24] = b;
                    14: w_bits = {8'h00, b};
                    15: w_bits[15:8] = b;
                    default: ;
                endcase
                advance_body();
            end
            PH_SKIP: advance_body();
            PH_DATA: begin
                frame_len = (w_chans == 16'd2) ? 32'd4 : 32'd2;
                k = pos & (frame_len - 32'd1);
                remaining = w_len - 32'd1 - pos;
                if (k == 0 || k == 2) begin
                    w_low = b;
                end else begin
                    word = {b, w_low};
                    if (k == 1 && frame_len == 4) begin
                        w_left = word;
                    end else begin
                        if (frame_len == 4)
                            sum = {w_left[15], w_left} + {word[15], word};
                        else
                            sum = {word, 1'b0};
                        got = 1'b1;
                        r = pack_result(ST_SAMPLE, sum, remaining < frame_len);
                    end
                end
                if (remaining == 0) begin
                    w_phase = PH_IDLE;
                    w_pos = '0;
                end else begin
                    w_pos = pos + 32'd1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk) begin : scoreboard
        logic        got;
        logic        took;
        t_wav_result r;
        t_wav_result act;
        t_wav_result want;
        took = 1'b0;
        if (!rst_n) begin
            clear_parser();
            quiet_cycles <= 0;
        end else begin
            if (s_valid && s_ready) begin
                took = 1'b1;
                parse_byte(s_data, s_first, got, r);
                if (s_pin)
                    expected_q = {expected_q, s_pin_res};
                else if (got)
                    expected_q = {expected_q, r};
            end
            if (m_valid && m_ready) begin
                took = 1'b1;
                act.status = m_status;
                act.mono   = m_data[16:0];
                act.rate   = m_data[48:17];
                act.chans  = m_data[64:49];
                act.last   = m_last;
                if (expected_q.size() == 0) begin
                    note_failure($sformatf("unexpected result: status %0d sample %0d",
                                           act.status, $signed(act.mono)));
                end else begin
                    want = expected_q.pop_front();
                    if (act.status !== want.status || act.mono !== want.mono ||
                        act.rate !== want.rate || act.chans !== want.chans ||
                        act.last !== want.last)
                        note_failure($sformatf({"mismatch: status %0d/%0d sample %0d/%0d",
                            " rate %h/%h chans %0d/%0d last %0d/%0d"},
                            want.status, act.status, $signed(want.mono), $signed(act.mono),
                            want.rate, act.rate, want.chans, act.chans, want.last, act.last));
                end
            end
            quiet_cycles <= took ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : receiver
        int stall;
        m_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = gaps_on ? $urandom_range(0, 4) : 0;
            @(negedge clk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!(m_valid && m_ready));
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic first,
                             input logic pin, input t_wav_result res);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid   <= 1'b1;
        s_data    <= b;
        s_first   <= first;
        s_pin     <= pin;
        s_pin_res <= res;
        do @(posedge clk); while (!(s_valid && s_ready));
        bytes_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_tag(input logic [31:0] tag);
        for (int i = 3; i >= 0; i--)
            file_q = {file_q, tag[8 * i +: 8]};
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_q = {file_q, v[8 * i +: 8]};
    endtask

    task automatic compose_wav(input int scn);
        logic [15:0] fmt_code;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] fmt_len;
        logic [31:0] data_len;
        logic [15:0] smp;
        int n_fmt;
        int n_pre;
        int n_frames;
        int partial;
        int frame_bytes;
        int idx;
        logic bad_hdr;
        logic extremes;
        logic zero_other;
        file_q.delete();
        fmt_code   = 16'd1;
        chans      = 16'($urandom_range(1, 2));
        bits       = 16'd16;
        rate       = $urandom;
        fmt_len    = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(17, 20)) : 32'd16;
        n_fmt      = 1;
        n_pre      = $urandom_range(0, 2);
        n_frames   = $urandom_range(1, 8);
        partial    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        bad_hdr    = 1'b0;
        extremes   = 1'b0;
        zero_other = 1'b0;
        case (scn)
            0: begin chans = 16'd2; extremes = 1'b1; end
            1: begin chans = 16'd1; extremes = 1'b1; end
            2: fmt_len = 32'd15;
            3: fmt_code = 16'd3;
            4: bits = 16'd8;
            5: chans = 16'd0;
            6: chans = 16'd3;
            7: begin n_frames = 0; partial = 0; end
            8: n_fmt = 0;
            9: begin n_pre = 2; zero_other = 1'b1; end
            10: begin chans = 16'd2; partial = 3; end
            11: begin n_frames = 0; partial = 1; end
            12: begin fmt_code = 16'd0; n_frames = 0; partial = 0; end
            13: begin n_fmt = 2; fmt_len = 32'd18; end
            14: chans = 16'h0102;
            default: begin
                case ($urandom_range(0, 24))
                    0: bad_hdr = 1'b1;
                    1: fmt_code = 16'($urandom);
                    2: bits = 16'($urandom);
                    3: chans = 16'($urandom);
                    4: fmt_len = 32'($urandom_range(0, 15));
                    5: n_fmt = 0;
                    6: begin n_frames = 0; partial = 0; end
                    7: n_fmt = 2;
                    default: ;
                endcase
            end
        endcase
        frame_bytes = (chans == 16'd2) ? 4 : 2;
        if (partial >= frame_bytes)
            partial = frame_bytes - 1;
        data_len = 32'(n_frames * frame_bytes + partial);

        put_tag(TAG_RIFF);
        put_le($urandom, 4);
        put_tag(TAG_WAVE);
        if (bad_hdr) begin
            idx = $urandom_range(0, 7);
            if (idx > 3)
                idx += 4;
            file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
        end
        for (int c = 0; c < n_pre; c++) begin
            idx = zero_other ? 0 : $urandom_range(0, 5);
            case ($urandom_range(0, 3))
                0: put_tag(32'h4C49_5354);
                1: put_tag(32'h4A55_4E4B);
                2: put_tag(32'h6661_6374);
                default: put_tag($urandom);
            endcase
            put_le(32'(idx), 4);
            for (int i = 0; i < idx; i++)
                file_q = {file_q, 8'($urandom)};
        end
        for (int c = 0; c < n_fmt; c++) begin
            put_tag(TAG_FMT);
            put_le(fmt_len, 4);
            if (fmt_len >= 16) begin
                put_le({16'd0, fmt_code}, 2);
                put_le({16'd0, chans}, 2);
                put_le(rate, 4);
                put_le($urandom, 4);
                put_le($urandom, 2);
                put_le({16'd0, bits}, 2);
                for (int i = 16; i < fmt_len; i++)
                    file_q = {file_q, 8'($urandom)};
            end
            rate = $urandom;
        end
        put_tag(TAG_DATA);
        put_le(data_len, 4);
        for (int f = 0; f < n_frames * frame_bytes / 2; f++) begin
            if (extremes)
                smp = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            else
                case ($urandom_range(0, 7))
                    0: smp = 16'h8000;
                    1: smp = 16'h7FFF;
                    2: smp = 16'hFFFF;
                    3: smp = 16'h0000;
                    default: smp = 16'($urandom);
                endcase
            put_le({16'd0, smp}, 2);
        end
        for (int i = 0; i < partial; i++)
            file_q = {file_q, 8'($urandom)};
    endtask

    task automatic send_file(input logic noisy);
        int cut;
        logic lead;
        cut = file_q.size();
        lead = 1'b1;
        if (noisy && $urandom_range(0, 19) == 0)
            cut = $urandom_range(1, file_q.size() - 1);
        if (noisy && $urandom_range(0, 29) == 0)
            lead = 1'b0;
        for (int i = 0; i < cut; i++)
            push_byte(file_q[i], (i == 0) ? lead : 1'b0, 1'b0, NO_RESULT);
        if (noisy)
            repeat ($urandom_range(0, 2))
                push_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
    endtask

    initial begin : stimulus
        int scn;
        rst_n        = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        s_first      = 1'b0;
        s_pin        = 1'b0;
        s_pin_res    = NO_RESULT;
        gaps_on      = 1'b1;
        failures     = 0;
        bytes_sent   = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIR_ROWS[i])
            push_byte(DIR_ROWS[i].b, DIR_ROWS[i].first, DIR_ROWS[i].pin, DIR_ROWS[i].res);
        drain_results();

        scn = 0;
        while (scn < N_SHAPED || bytes_sent < TOTAL_BYTES) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            compose_wav(scn);
            send_file(scn >= N_SHAPED);
            if (scn % 6 == 5)
                drain_results();
            scn++;
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (failures == 0 && expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
